[src/bsl_pkg.sv]
package bsl_pkg;

	// Port widths of the transaction fields
	localparam int VALUE_BITS = 64;
	localparam int KIND_BITS  = 5;
	localparam int SHAMT_BITS = 6;

	// Datapath width: values are cut to their low WORD_BITS bits
	localparam int WORD_BITS = 64;
	localparam int IDX_BITS  = $clog2(WORD_BITS);
	localparam int POS_BITS  = IDX_BITS + 1;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [WORD_BITS-1:0]  word_t;
	typedef logic [KIND_BITS-1:0]  kind_t;
	typedef logic [SHAMT_BITS-1:0] shamt_t;
	typedef logic [POS_BITS-1:0]   pos_t;

	// Operation codes
	localparam kind_t KIND_SLI     = 5'd0;
	localparam kind_t KIND_SRI     = 5'd1;
	localparam kind_t KIND_SLORI   = 5'd2;
	localparam kind_t KIND_SRORI   = 5'd3;
	localparam kind_t KIND_SLANDI  = 5'd4;
	localparam kind_t KIND_SRANDI  = 5'd5;
	localparam kind_t KIND_SLORII  = 5'd6;
	localparam kind_t KIND_SRORII  = 5'd7;
	localparam kind_t KIND_SLANDII = 5'd8;
	localparam kind_t KIND_SRANDII = 5'd9;
	localparam kind_t KIND_SARI    = 5'd10;
	localparam kind_t KIND_SR      = 5'd11;
	localparam kind_t KIND_SL      = 5'd12;
	localparam kind_t KIND_SAR     = 5'd13;
	localparam kind_t KIND_ANDI    = 5'd14;
	localparam kind_t KIND_AND     = 5'd15;
	localparam kind_t KIND_OR      = 5'd16;
	localparam kind_t KIND_XOR     = 5'd17;
	localparam kind_t KIND_ORI     = 5'd18;
	localparam kind_t KIND_XORI    = 5'd19;
	localparam kind_t KIND_SWIZ    = 5'd20;

	// Result of a prefix scan over the bit positions
	typedef struct packed {
		logic [WORD_BITS-1:0]            v;
		logic [WORD_BITS-1:0][POS_BITS-1:0] p;
	} scan_t;

	// Result of the shift / logic datapath
	typedef struct packed {
		word_t value;
		logic  illegal;
	} alu_res_t;

endpackage

[src/bsl_shift_logic.sv]
module bsl_shift_logic (
	input  bsl_pkg::kind_t    kind,
	input  bsl_pkg::word_t    src,
	input  bsl_pkg::word_t    dst,
	input  bsl_pkg::word_t    sec,
	input  bsl_pkg::value_t   sec_full,
	input  bsl_pkg::shamt_t   shift_imm,
	input  bsl_pkg::word_t    imm,
	output bsl_pkg::alu_res_t res
);
	import bsl_pkg::*;

	logic                reg_amt;
	value_t              amt;
	logic                big;
	logic [IDX_BITS-1:0] sh;
	word_t               shl;
	word_t               shr;
	word_t               sar;

	// Shift amount: register amount for sr/sl/sar, else the immediate
	assign reg_amt = (kind == KIND_SR) || (kind == KIND_SL) || (kind == KIND_SAR);
	assign amt     = reg_amt ? sec_full : VALUE_BITS'(shift_imm);
	assign big     = amt >= VALUE_BITS'(WORD_BITS);
	assign sh      = amt[IDX_BITS-1:0];

	// One shifter of each kind, saturating on an oversize amount
	assign shl = big ? '0 : (src << sh);
	assign shr = big ? '0 : (src >> sh);
	assign sar = big ? {WORD_BITS{src[WORD_BITS-1]}} : word_t'($signed(src) >>> sh);

	// Operation select
	always_comb begin
		res.illegal = 1'b0;
		case (kind)
			KIND_SLI:     res.value = shl;
			KIND_SRI:     res.value = shr;
			KIND_SLORI:   res.value = dst | shl;
			KIND_SRORI:   res.value = dst | shr;
			KIND_SLANDI:  res.value = dst & shl;
			KIND_SRANDI:  res.value = dst & shr;
			KIND_SLORII:  res.value = imm | shl;
			KIND_SRORII:  res.value = imm | shr;
			KIND_SLANDII: res.value = imm & shl;
			KIND_SRANDII: res.value = imm & shr;
			KIND_SARI:    res.value = sar;
			KIND_SR:      res.value = shr;
			KIND_SL:      res.value = shl;
			KIND_SAR:     res.value = sar;
			KIND_ANDI:    res.value = src & imm;
			KIND_AND:     res.value = src & sec;
			KIND_OR:      res.value = src | sec;
			KIND_XOR:     res.value = src ^ sec;
			KIND_ORI:     res.value = src | imm;
			KIND_XORI:    res.value = src ^ imm;
			KIND_SWIZ:    res.value = '0;
			default: begin
				res.value   = '0;
				res.illegal = 1'b1;
			end
		endcase
	end

endmodule

[src/bsl_swizzle.sv]
module bsl_swizzle (
	input  bsl_pkg::word_t mask,
	input  bsl_pkg::word_t data,
	output bsl_pkg::word_t swizzled
);
	import bsl_pkg::*;

	// Nearest set flag at or below each position (log-depth scan)
	function automatic scan_t scan_last(input word_t f);
		scan_t sc;
		int    i;
		int    k;
		for (i = 0; i < WORD_BITS; i++) begin
			sc.v[i] = f[i];
			sc.p[i] = POS_BITS'(i);
		end
		for (k = 0; k < IDX_BITS; k++) begin
			for (i = WORD_BITS - 1; i >= 0; i--) begin
				if (i >= (1 << k) && !sc.v[i]) begin
					sc.v[i] = sc.v[i - (1 << k)];
					sc.p[i] = sc.p[i - (1 << k)];
				end
			end
		end
		return sc;
	endfunction

	// Nearest set flag at or above each position
	function automatic scan_t scan_next(input word_t f);
		scan_t sc;
		int    i;
		int    k;
		for (i = 0; i < WORD_BITS; i++) begin
			sc.v[i] = f[i];
			sc.p[i] = POS_BITS'(i);
		end
		for (k = 0; k < IDX_BITS; k++) begin
			for (i = 0; i < WORD_BITS; i++) begin
				if (i + (1 << k) < WORD_BITS && !sc.v[i]) begin
					sc.v[i] = sc.v[i + (1 << k)];
					sc.p[i] = sc.p[i + (1 << k)];
				end
			end
		end
		return sc;
	endfunction

	word_t mprev;
	word_t seg_start;
	word_t rise;
	word_t start_above;
	scan_t last_start;
	scan_t last_rise;
	scan_t next_rise;
	scan_t next_start;

	// A pair starts where a zero follows a one (or at bit 0 if it is zero);
	// the ones part starts where a one follows a zero
	assign mprev       = {mask[WORD_BITS-2:0], 1'b1};
	assign seg_start   = ~mask & mprev;
	assign rise        = mask & ~mprev;
	assign start_above = {1'b0, seg_start[WORD_BITS-1:1]};

	assign last_start = scan_last(seg_start);
	assign last_rise  = scan_last(rise);
	assign next_rise  = scan_next(rise);
	assign next_start = scan_next(start_above);

	// Per bit: the pair [s,c) is rotated so the ones field lands at the bottom
	always_comb begin
		pos_t s;
		pos_t e;
		pos_t c;
		pos_t zl;
		pos_t ol;
		pos_t off;
		pos_t j;
		logic keep;
		for (int i = 0; i < WORD_BITS; i++) begin
			s    = last_start.p[i];
			keep = !last_start.v[i];
			if (mask[i]) begin
				e = last_rise.p[i];
			end else begin
				e = next_rise.p[i];
				if (!next_rise.v[i])
					keep = 1'b1;
			end
			c   = next_start.v[i] ? pos_t'(next_start.p[i] + 1'b1) : pos_t'(WORD_BITS);
			zl  = pos_t'(e - s);
			ol  = pos_t'(c - e);
			off = pos_t'(POS_BITS'(i) - s);
			if (keep)
				j = POS_BITS'(i);
			else if (off < ol)
				j = pos_t'(POS_BITS'(i) + zl);
			else
				j = pos_t'(POS_BITS'(i) - ol);
			swizzled[i] = data[j[IDX_BITS-1:0]];
		end
	end

endmodule

[src/bitwise_shift_logic_swizzle_unit.sv]
// Channel | Handshake           | Fields
// --------+---------------------+---------------------------------------------
// in      | in_valid / in_stall | kind, src_value, dst_old_value,
//         |                     | second_value, shift_imm, imm_value
// out     | out_valid/out_stall | result, illegal
//
// Two register stages: operands are captured in the input register, then the
// result register is loaded from the datapath.
// One transaction per cycle is accepted while in_stall is low; no state carries between them.
// arst_n clears only the stage valid bits.
// out_stall freezes the result register; the input register still fills if
// empty, so in_stall rises only when both stages hold a transaction.
module bitwise_shift_logic_swizzle_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bsl_pkg::kind_t   kind,
	input  bsl_pkg::value_t  src_value,
	input  bsl_pkg::value_t  dst_old_value,
	input  bsl_pkg::value_t  second_value,
	input  bsl_pkg::shamt_t  shift_imm,
	input  bsl_pkg::value_t  imm_value,
	output logic             out_valid,
	input  logic             out_stall,
	output bsl_pkg::value_t  result,
	output logic             illegal
);
	import bsl_pkg::*;

	logic     valid_s1;
	kind_t    kind_s1;
	value_t   src_s1;
	value_t   dst_s1;
	value_t   sec_s1;
	shamt_t   shamt_s1;
	value_t   imm_s1;
	logic     valid_s2;
	word_t    result_s2;
	logic     illegal_s2;
	logic     advance;
	logic     load_s1;
	alu_res_t alu_res;
	word_t    swiz_res;
	word_t    next_res;

	// Flow control
	assign advance  = !(valid_s2 && out_stall);
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			kind_s1  <= kind;
			src_s1   <= src_value;
			dst_s1   <= dst_old_value;
			sec_s1   <= second_value;
			shamt_s1 <= shift_imm;
			imm_s1   <= imm_value;
		end
	end

	// Datapath
	bsl_shift_logic u_shift_logic (
		.kind      (kind_s1),
		.src       (src_s1[WORD_BITS-1:0]),
		.dst       (dst_s1[WORD_BITS-1:0]),
		.sec       (sec_s1[WORD_BITS-1:0]),
		.sec_full  (VALUE_BITS'(sec_s1[WORD_BITS-1:0])),
		.shift_imm (shamt_s1),
		.imm       (imm_s1[WORD_BITS-1:0]),
		.res       (alu_res)
	);

	bsl_swizzle u_swizzle (
		.mask     (src_s1[WORD_BITS-1:0]),
		.data     (dst_s1[WORD_BITS-1:0]),
		.swizzled (swiz_res)
	);

	assign next_res = (kind_s1 == KIND_SWIZ) ? swiz_res : alu_res.value;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2  <= next_res;
			illegal_s2 <= alu_res.illegal;
		end
	end

	assign out_valid = valid_s2;
	assign result    = VALUE_BITS'(result_s2);
	assign illegal   = illegal_s2;

	// Checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output");

	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && illegal) |-> (result == '0))
		else $error("illegal transaction carries a nonzero result");

	a_fill_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transaction not held in the input stage");

endmodule
